/* hw/rtl/lbpr_pkg.sv */
// ---------------------------------------------------------------------------
// lbpr_pkg
// Shared constants and types for the longest balanced bracket run unit.
// ---------------------------------------------------------------------------
package lbpr_pkg;

   // longest string the unit tracks, in characters
   localparam int MaxLen    = 4096;
   localparam int PosWidth  = $clog2(MaxLen);
   localparam int CntWidth  = $clog2(MaxLen + 1);
   localparam int SymWidth  = 8;
   localparam int RunWidth  = 13;
   localparam int SatWidth  = (CntWidth > RunWidth) ? CntWidth : RunWidth;

   localparam logic [SymWidth-1:0] OpenSymbol = 8'd40;
   localparam logic [RunWidth-1:0] RunMax     = '1;
   localparam logic [CntWidth-1:0] MaxPos     = CntWidth'(MaxLen);

   // one character handed from the input register to the scanner
   typedef struct packed {
      logic                fire;
      logic [SymWidth-1:0] symbol;
      logic                last;
   } lbpr_step_type;

   // one result handed from the scanner to the output register
   typedef struct packed {
      logic [RunWidth-1:0] longest_run;
      logic                string_end;
      logic                overflow;
   } lbpr_result_type;

endpackage

/* hw/rtl/lbpr_stack.sv */
// ---------------------------------------------------------------------------
// lbpr_stack
// Stack of open bracket positions: one write port, one registered read port.
// ---------------------------------------------------------------------------
module lbpr_stack
   import lbpr_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PosWidth-1:0] wr_addr,
   input  logic [PosWidth-1:0] wr_data,
   input  logic [PosWidth-1:0] rd_addr,
   output logic [PosWidth-1:0] rd_data
);

   logic [PosWidth-1:0] mem [MaxLen];
   logic [PosWidth-1:0] rd_data_ff;

   // write the pushed position
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // register the read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lbpr_scan.sv */
// ---------------------------------------------------------------------------
// lbpr_scan
// Per-character scan state: stack depth, barrier, position, best run and
// overflow. The stack read port always holds the entry below the top, so a
// pop finds its new start without waiting.
// ---------------------------------------------------------------------------
module lbpr_scan
   import lbpr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  lbpr_step_type   step,
   output lbpr_result_type result
);

   logic [CntWidth-1:0] count_ff, count_in;
   logic [CntWidth-1:0] pos_ff, pos_in;
   logic [CntWidth-1:0] barrier_ff, barrier_in;   // barrier position plus one
   logic [CntWidth-1:0] best_ff, best_in;
   logic                ovf_ff, ovf_in;

   logic                wr_en;
   logic [PosWidth-1:0] rd_addr;
   logic [PosWidth-1:0] rd_data;
   logic [CntWidth-1:0] here_p1;
   logic [CntWidth-1:0] below_p1;
   logic [CntWidth-1:0] start_p1;
   logic [CntWidth-1:0] span;
   logic [SatWidth-1:0] best_wide;
   logic [CntWidth-1:0] rd_count;

   assign here_p1  = pos_ff + CntWidth'(1);
   assign below_p1 = CntWidth'(rd_data) + CntWidth'(1);

   // apply one character and form its result
   always_comb begin
      count_in   = count_ff;
      pos_in     = pos_ff;
      barrier_in = barrier_ff;
      best_in    = best_ff;
      ovf_in     = ovf_ff;
      wr_en      = 1'b0;
      start_p1   = '0;
      span       = '0;
      if (step.fire) begin
         if (pos_ff == MaxPos) begin
            ovf_in = 1'b1;
         end else begin
            pos_in = here_p1;
            if (step.symbol == OpenSymbol) begin
               wr_en    = 1'b1;
               count_in = count_ff + CntWidth'(1);
            end else if (count_ff == '0) begin
               barrier_in = here_p1;
            end else begin
               count_in = count_ff - CntWidth'(1);
               start_p1 = (count_ff == CntWidth'(1)) ? barrier_ff : below_p1;
               span     = here_p1 - start_p1;
               if (span > best_ff) begin
                  best_in = span;
               end
            end
         end
      end

      // saturate the reported run to the field width
      best_wide          = SatWidth'(best_in);
      result.longest_run = (best_wide > SatWidth'(RunMax)) ? RunMax
                                                           : best_wide[RunWidth-1:0];
      result.string_end  = step.last;
      result.overflow    = ovf_in;

      // drop all state once the string ends
      if (step.fire && step.last) begin
         count_in   = '0;
         pos_in     = '0;
         barrier_in = '0;
         best_in    = '0;
         ovf_in     = 1'b0;
      end
   end

   // prefetch the entry below the next top
   assign rd_count = count_in - CntWidth'(2);
   assign rd_addr  = rd_count[PosWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pos_ff     <= '0;
         barrier_ff <= '0;
         best_ff    <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         count_ff   <= count_in;
         pos_ff     <= pos_in;
         barrier_ff <= barrier_in;
         best_ff    <= best_in;
         ovf_ff     <= ovf_in;
      end
   end

   lbpr_stack u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[PosWidth-1:0]),
      .wr_data (pos_ff[PosWidth-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

`ifndef SYNTH
   a_count_le_pos: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pos_ff)
      else $error("stack deeper than characters taken");

   a_best_le_pos: assert property (@(posedge clock) disable iff (reset)
      best_ff <= pos_ff)
      else $error("best run longer than characters taken");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> pos_ff == MaxPos)
      else $error("overflow set before the string filled");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step.fire && step.last |=> pos_ff == '0 && count_ff == '0 && !ovf_ff)
      else $error("state not cleared after end of string");
`endif

endmodule

/* hw/rtl/longest_balanced_paren_run_unit.sv */
// ---------------------------------------------------------------------------
// longest_balanced_paren_run_unit
// Longest balanced bracket run over a character stream.
// ---------------------------------------------------------------------------
// Usage: send one character per request on req_symbol, with req_last high on
// the final character of a string. '(' opens, every other byte closes. Each
// request returns one response: rsp_longest_run is the longest balanced run
// in the string so far, rsp_string_end echoes req_last, and rsp_overflow is
// high once the string ran past MaxLen characters (later characters ignored).
// After the response for the last character all scan state is cleared.
// Path: a request that is taken is registered in the input register, then
// scanned into the response register, which drives rsp_valid; a full
// response register that is not drained holds it in the input register.
// Throughput: one request per cycle while responses are drained, since the
// scan step is combinational and the stack read is always prefetched.
// Reset: synchronous, clears the scan state and both valid flags.
// Stall: while rsp_ready is low the response holds; one further request
// waits in the input register, then req_ready drops.
// ---------------------------------------------------------------------------
module longest_balanced_paren_run_unit
   import lbpr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SymWidth-1:0] req_symbol,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [RunWidth-1:0] rsp_longest_run,
   output logic                rsp_string_end,
   output logic                rsp_overflow
);

   logic                in_valid_ff, in_valid_in;
   logic [SymWidth-1:0] in_symbol_ff;
   logic                in_last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   lbpr_result_type     rsp_ff;
   logic                take;
   logic                advance;
   lbpr_step_type       step;
   lbpr_result_type     result;

   // advance when the response register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign step.fire   = advance;
   assign step.symbol = in_symbol_ff;
   assign step.last   = in_last_ff;

   lbpr_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_symbol_ff <= req_symbol;
         in_last_ff   <= req_last;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_longest_run = rsp_ff.longest_run;
   assign rsp_string_end  = rsp_ff.string_end;
   assign rsp_overflow    = rsp_ff.overflow;

endmodule

/* verif/tb_longest_balanced_paren_run_unit.sv */
// ---------------------------------------------------------------------------
// tb_longest_balanced_paren_run_unit
// Self-checking bench for the longest balanced bracket run unit.
// ---------------------------------------------------------------------------
// Character strings are sent one request at a time. A scoreboard predicts the
// response of every accepted request from its own copy of the scan state:
// the stack of open positions, the barrier, the running best and the sticky
// overflow flag. Each accepted response is checked field by field in order.
// The stimulus opens with short hand-picked strings. The rest is random
// strings, mostly bracket text, some noise.
// Both sides idle at random, except for one stretch where neither does.
// ---------------------------------------------------------------------------
module tb_longest_balanced_paren_run_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lbpr_pkg::*;

   localparam logic [SymWidth-1:0] CloseSymbol = 8'd41;
   localparam int RandomItems = 1630;
   localparam int CalmItems   = 300;
   localparam int StallLimit  = 2000;
   localparam int EndSettle   = 10;

   // Scoreboard: predict one response per accepted request, check in order
   class paren_run_tracker;
      lbpr_result_type     expected_runs[$];
      logic [PosWidth-1:0] open_pos[MaxLen];
      int                  depth;
      int                  barrier;
      int                  pos;
      int                  best;
      bit                  overflowed;
      int                  mismatches;

      function new();
         mismatches = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         depth      = 0;
         barrier    = -1;
         pos        = 0;
         best       = 0;
         overflowed = 1'b0;
      endfunction

      function void note_request(logic [SymWidth-1:0] sym, logic last);
         int              here;
         int              start;
         lbpr_result_type res;
         // ignore characters past the window, but flag them
         if (pos >= MaxLen) begin
            overflowed = 1'b1;
         end else begin
            here = pos;
            pos++;
            if (sym == OpenSymbol) begin
               if (depth < MaxLen) begin
                  open_pos[depth] = PosWidth'(here);
                  depth++;
               end
            end else if (depth == 0) begin
               barrier = here;
            end else begin
               // pop, then measure back to the new top or to the barrier
               depth--;
               start = (depth == 0) ? barrier : int'(open_pos[depth-1]);
               if (here - start > best) best = here - start;
            end
         end
         res.longest_run = (best > int'(RunMax)) ? RunMax : RunWidth'(best);
         res.string_end  = last;
         res.overflow    = overflowed;
         expected_runs.push_back(res);
         if (last) clear_scan();
      endfunction

      function void check_response(logic [RunWidth-1:0] run, logic str_end, logic ovf);
         lbpr_result_type exp;
         if (expected_runs.size() == 0) begin
            $display("%0t: response with none expected: run %0d end %0b overflow %0b",
                     $time, run, str_end, ovf);
            mismatches++;
            return;
         end
         exp = expected_runs.pop_front();
         if (run !== exp.longest_run) begin
            $display("%0t: longest_run expected %0d, actual %0d", $time, exp.longest_run, run);
            mismatches++;
         end
         if (str_end !== exp.string_end) begin
            $display("%0t: string_end expected %0b, actual %0b", $time, exp.string_end, str_end);
            mismatches++;
         end
         if (ovf !== exp.overflow) begin
            $display("%0t: overflow expected %0b, actual %0b", $time, exp.overflow, ovf);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction
   endclass

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_valid  = 1'b0;
   logic                req_ready;
   logic [SymWidth-1:0] req_symbol = '0;
   logic                req_last   = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready  = 1'b0;
   logic [RunWidth-1:0] rsp_longest_run;
   logic                rsp_string_end;
   logic                rsp_overflow;

   paren_run_tracker board = new();
   int               requests_taken = 0;
   int               requests_sent  = 0;
   int               quiet_cycles   = 0;
   bit               calm           = 1'b0;

   longest_balanced_paren_run_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_symbol      (req_symbol),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_longest_run (rsp_longest_run),
      .rsp_string_end  (rsp_string_end),
      .rsp_overflow    (rsp_overflow)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watch both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_symbol, req_last);
            requests_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_longest_run, rsp_string_end, rsp_overflow);
         end
      end
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Stall the response side at random, except in the calm stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
      end
   end

   // Send one character and hold it until accepted
   task automatic send_char(input logic [SymWidth-1:0] sym, input logic last);
      int taken;
      taken = requests_taken;
      if (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 30);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      req_last   <= last;
      do @(negedge clock); while (requests_taken == taken);
      requests_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_char(text[i], i == text.len() - 1);
      end
   endtask

   // Mostly brackets, with an occasional arbitrary byte
   function automatic logic [SymWidth-1:0] pick_symbol();
      int roll;
      roll = $urandom_range(99);
      if (roll < 48) return OpenSymbol;
      if (roll < 90) return CloseSymbol;
      return SymWidth'($urandom_range(255));
   endfunction

   initial begin
      int random_goal;
      int calm_from;
      int len;
      bit noisy;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: nesting, barrier moves, pop back to the barrier, odd closers
      send_text("()");
      send_text("(()");
      send_text(")()())");
      send_text("()(())");
      send_char(OpenSymbol, 1'b1);
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);
      send_char(8'd39, 1'b0);
      send_char(~OpenSymbol, 1'b0);
      send_char(CloseSymbol, 1'b1);

      // Random strings, mostly short, with a stretch free of idling
      random_goal = requests_sent + RandomItems;
      calm_from   = requests_sent + RandomItems / 3;
      while (requests_sent < random_goal) begin
         calm  = (requests_sent >= calm_from) && (requests_sent < calm_from + CalmItems);
         len   = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 24);
         noisy = $urandom_range(99) < 15;
         for (int i = 0; i < len; i++) begin
            send_char(noisy ? SymWidth'($urandom_range(255)) : pick_symbol(), i == len - 1);
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Drain outstanding responses, then settle
      while (board.pending() != 0) @(posedge clock);
      repeat (EndSettle) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/lbpr_pkg.sv
hw/rtl/lbpr_stack.sv
hw/rtl/lbpr_scan.sv
hw/rtl/longest_balanced_paren_run_unit.sv
verif/tb_longest_balanced_paren_run_unit.sv
